FILE: hdl/pius_pkg.sv
// types, constants and codes shared by the usage statistics table
package pius_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 64;
    localparam int AMT_W       = 32;
    localparam int OP_W        = 2;

    typedef logic [ADDR_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [AMT_W-1:0]  amt_t;

    // operation codes; the unused code behaves as a query
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // engine sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_CALC  = 3'd2,
        ST_DELTA = 3'd3,
        ST_TOTAL = 3'd4
    } state_t;

    // one table entry as held in the store
    typedef struct packed {
        cnt_t current;
        cnt_t peak;
        cnt_t allocs;
        cnt_t frees;
    } entry_t;

    // store access request from the engine
    typedef struct packed {
        logic   wr_en;
        slot_t  wr_addr;
        entry_t wr_data;
        logic   rd_en;
        slot_t  rd_addr;
    } mem_req_t;

    // result beat handed to the output register
    typedef struct packed {
        entry_t entry;
        cnt_t   sum_current;
        cnt_t   sum_peak;
        cnt_t   sum_allocs;
    } result_t;

endpackage

FILE: hdl/pius_store.sv
// entry store: one write port, one registered read port
module pius_store (
    input  logic              aclk,
    input  pius_pkg::mem_req_t req,
    output pius_pkg::entry_t   rd_data
);
    import pius_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/pius_engine.sv
// sequencer: clearing pass, read-modify-write of one entry, running totals
module pius_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [63:0]           s_owner_id,
    input  logic [31:0]           s_byte_amount,
    output pius_pkg::mem_req_t    mem_req,
    input  pius_pkg::entry_t      rd_data,
    output logic                  res_valid,
    input  logic                  res_free,
    output pius_pkg::result_t     res
);
    import pius_pkg::*;

    state_t state_reg, state_next;
    slot_t  clr_addr_reg;
    cnt_t   tot_current_reg;
    cnt_t   tot_peak_reg;
    cnt_t   tot_alloc_reg;

    op_t    op_reg;
    slot_t  slot_reg;
    amt_t   amount_reg;
    entry_t entry_reg;
    cnt_t   old_peak_reg;
    cnt_t   peak_delta_reg;

    entry_t upd;
    cnt_t   amt_ext;
    cnt_t   cur_sum;
    logic   accept;
    logic   clr_done;

    assign accept   = s_valid && s_ready;
    assign clr_done = (clr_addr_reg == slot_t'(TABLE_DEPTH - 1));
    assign amt_ext  = {{(CNT_W - AMT_W){1'b0}}, amount_reg};

    // entry update from the freshly read entry
    always_comb begin
        upd     = rd_data;
        cur_sum = rd_data.current + amt_ext;
        case (op_reg)
            OP_ALLOC: begin
                upd.current = cur_sum;
                upd.peak    = (cur_sum > rd_data.peak) ? cur_sum : rd_data.peak;
                upd.allocs  = rd_data.allocs + 64'd1;
            end
            OP_FREE: begin
                upd.current = rd_data.current - amt_ext;
                upd.frees   = rd_data.frees + 64'd1;
            end
            default: begin
                upd = rd_data;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_done) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_CALC;
            ST_CALC:  state_next = ST_DELTA;
            ST_DELTA: state_next = ST_TOTAL;
            ST_TOTAL: if (res_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // outputs by state
    always_comb begin
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = slot_reg;
        mem_req.wr_data = upd;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = s_owner_id[ADDR_W-1:0];
        case (state_reg)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_addr_reg;
                mem_req.wr_data = '0;
            end
            ST_IDLE: begin
                s_ready       = 1'b1;
                mem_req.rd_en = s_valid;
            end
            ST_CALC: begin
                mem_req.wr_en = 1'b1;
            end
            ST_TOTAL: begin
                res_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result beat: peak total is folded in as it is loaded
    always_comb begin
        res.entry       = entry_reg;
        res.sum_current = tot_current_reg;
        res.sum_peak    = tot_peak_reg + peak_delta_reg;
        res.sum_allocs  = tot_alloc_reg;
    end

    // control state and running totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            tot_current_reg <= '0;
            tot_peak_reg    <= '0;
            tot_alloc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == ST_DELTA) begin
                case (op_reg)
                    OP_ALLOC: begin
                        tot_current_reg <= tot_current_reg + amt_ext;
                        tot_alloc_reg   <= tot_alloc_reg + 64'd1;
                    end
                    OP_FREE: begin
                        tot_current_reg <= tot_current_reg - amt_ext;
                    end
                    default: begin
                        tot_current_reg <= tot_current_reg;
                    end
                endcase
            end
            if (state_reg == ST_TOTAL && res_free) begin
                tot_peak_reg <= res.sum_peak;
            end
        end
    end

    // beat payload and update pipeline
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= op_t'(s_operation);
            slot_reg   <= s_owner_id[ADDR_W-1:0];
            amount_reg <= s_byte_amount;
        end
        if (state_reg == ST_CALC) begin
            entry_reg    <= upd;
            old_peak_reg <= rd_data.peak;
        end
        if (state_reg == ST_DELTA) begin
            peak_delta_reg <= entry_reg.peak - old_peak_reg;
        end
    end

endmodule

FILE: hdl/per_id_usage_statistics_table.sv
// Per-owner usage statistics table. Each owner id selects an entry by its low
// ten bits; an allocation or free beat updates that entry's counters and the
// running table-wide sums, a query beat only reads them, and every beat returns
// one result. After reset the block clears all 1024 entries of the entry
// store (s_ready low), then takes beats one at a time: read of the single
// entry store, update and write-back, peak difference, total update. The
// result sits in an output register, so a new beat is taken while it waits;
// when the result register is still full, the beat after that waits for it.
module per_id_usage_statistics_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [63:0] s_owner_id,
    input  logic [31:0] s_byte_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_entry_current,
    output logic [63:0] m_entry_peak,
    output logic [63:0] m_entry_allocs,
    output logic [63:0] m_entry_frees,
    output logic [63:0] m_sum_current,
    output logic [63:0] m_sum_peak,
    output logic [63:0] m_sum_allocs
);
    import pius_pkg::*;

    mem_req_t mem_req;
    entry_t   rd_data;
    result_t  res;
    logic     res_valid;
    logic     res_free;
    logic     m_valid_reg;
    result_t  out_reg;

    pius_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    pius_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_owner_id    (s_owner_id),
        .s_byte_amount (s_byte_amount),
        .mem_req       (mem_req),
        .rd_data       (rd_data),
        .res_valid     (res_valid),
        .res_free      (res_free),
        .res           (res)
    );

    // output register frees when empty or taken this cycle
    assign res_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_entry_current = out_reg.entry.current;
    assign m_entry_peak    = out_reg.entry.peak;
    assign m_entry_allocs  = out_reg.entry.allocs;
    assign m_entry_frees   = out_reg.entry.frees;
    assign m_sum_current   = out_reg.sum_current;
    assign m_sum_peak      = out_reg.sum_peak;
    assign m_sum_allocs    = out_reg.sum_allocs;

endmodule
